// ===== hw/rtl/image_scale_by_two_assert.svh =====
// Assertion helpers for the scaler RTL.
`ifndef IMAGE_SCALE_BY_TWO_ASSERT_SVH
`define IMAGE_SCALE_BY_TWO_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ISBT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scaler assertion failed (same cycle)");

// Consequent must hold in the cycle after the antecedent.
`define ISBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scaler assertion failed (next cycle)");

`endif

// ===== hw/rtl/isbt_pkg.sv =====
package isbt_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 13;
  localparam int COL_W      = 11;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int SUM_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int BEAT_W     = 2;

  localparam logic [FW_W-1:0]   FW_RST    = FW_W'(1024);
  localparam logic [FH_W-1:0]   FH_RST    = FH_W'(1024);
  localparam logic [BEAT_W-1:0] BEAT_LAST = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    MODE_UP   = 1'b0,
    MODE_DOWN = 1'b1
  } scale_mode_t;

  // One accepted pixel that gives results: base target position and data.
  typedef struct packed {
    logic             up;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [SUM_W-1:0] pair;
  } scale_item_t;

endpackage

// ===== hw/rtl/isbt_line_mem.sv =====
module isbt_line_mem #(
  parameter int DEPTH = isbt_pkg::MAX_WIDTH_DEF / 2,
  parameter int AW    = 9
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [isbt_pkg::SUM_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [isbt_pkg::SUM_W-1:0] rd_data
);
  import isbt_pkg::*;

  logic [SUM_W-1:0] mem_r [DEPTH];
  logic [SUM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/isbt_front.sv =====
module isbt_front #(
  parameter int MAX_WIDTH  = isbt_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = isbt_pkg::MAX_HEIGHT_DEF,
  localparam int CW  = ($clog2(MAX_WIDTH) > 2) ? $clog2(MAX_WIDTH) : 2,
  localparam int LAW = CW - 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [isbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [isbt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_fire,
  input  logic [isbt_pkg::PIX_W-1:0]      in_pixel,
  output logic                            item_load,
  output isbt_pkg::scale_item_t           item,
  output logic                            wr_en,
  output logic [LAW-1:0]                  wr_addr,
  output logic [isbt_pkg::SUM_W-1:0]      wr_data,
  output logic                            rd_en,
  output logic [LAW-1:0]                  rd_addr
);
  import isbt_pkg::*;

  localparam int RW  = ($clog2(MAX_HEIGHT) > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCW = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
  localparam int RCW = ($clog2(MAX_HEIGHT + 1) > FH_W) ? $clog2(MAX_HEIGHT + 1) : FH_W;
  localparam logic [WCW-1:0] MAXW = WCW'(MAX_WIDTH);
  localparam logic [RCW-1:0] MAXH = RCW'(MAX_HEIGHT);

  scale_mode_t      mode_r, mode_nxt;
  logic [FW_W-1:0]  fw_r, fw_nxt;
  logic [FH_W-1:0]  fh_r, fh_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [PIX_W-1:0] held_r, held_nxt;

  logic [WCW-1:0]   w_eff, col_inc;
  logic [RCW-1:0]   h_eff, row_inc;
  logic             is_up, odd_c, odd_r;
  logic [SUM_W-1:0] pair;

  // Register writes
  always_comb begin
    mode_nxt = mode_r;
    fw_nxt   = fw_r;
    fh_nxt   = fh_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode_nxt = scale_mode_t'(cfg_data[0]);
        REG_WIDTH:  fw_nxt   = cfg_data[FW_W-1:0];
        REG_HEIGHT: fh_nxt   = cfg_data[FH_W-1:0];
        default:    ;
      endcase
    end
  end

  // Clamp geometry
  always_comb begin
    w_eff = WCW'(fw_r);
    if (w_eff == '0) begin
      w_eff = WCW'(1);
    end else if (w_eff > MAXW) begin
      w_eff = MAXW;
    end
    h_eff = RCW'(fh_r);
    if (h_eff == '0) begin
      h_eff = RCW'(1);
    end else if (h_eff > MAXH) begin
      h_eff = MAXH;
    end
  end

  assign col_inc = WCW'(col_r) + WCW'(1);
  assign row_inc = RCW'(row_r) + RCW'(1);

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    held_nxt = held_r;
    if (in_fire) begin
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_eff) ? '0 : RW'(row_inc);
      end else begin
        col_nxt = CW'(col_inc);
      end
      if (!is_up && !odd_c) begin
        held_nxt = in_pixel;
      end
    end
  end

  assign is_up = (mode_r == MODE_UP);
  assign odd_c = col_r[0];
  assign odd_r = row_r[0];
  assign pair  = {1'b0, held_r} + {1'b0, in_pixel};

  always_comb begin
    item.up   = is_up;
    item.row  = is_up ? ROW_W'({row_r, 1'b0}) : ROW_W'(row_r >> 1);
    item.col  = is_up ? COL_W'({col_r, 1'b0}) : COL_W'(col_r >> 1);
    item.pair = is_up ? {1'b0, in_pixel} : pair;
  end

  assign item_load = in_fire && (is_up || (odd_c && odd_r));
  assign wr_en     = in_fire && !is_up && odd_c && !odd_r;
  assign wr_addr   = col_r[CW-1:1];
  assign wr_data   = pair;
  assign rd_en     = in_fire && !is_up && odd_c && odd_r;
  assign rd_addr   = col_r[CW-1:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_UP;
      fw_r   <= FW_RST;
      fh_r   <= FH_RST;
      col_r  <= '0;
      row_r  <= '0;
      held_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      fw_r   <= fw_nxt;
      fh_r   <= fh_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ===== hw/rtl/isbt_emit.sv =====
`include "image_scale_by_two_assert.svh"

module isbt_emit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       item_load,
  input  isbt_pkg::scale_item_t      item,
  input  logic [isbt_pkg::SUM_W-1:0] rd_data,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [isbt_pkg::ROW_W-1:0] out_row,
  output logic [isbt_pkg::COL_W-1:0] out_col,
  output logic [isbt_pkg::PIX_W-1:0] out_value,
  output logic                       out_last_of_item
);
  import isbt_pkg::*;

  scale_item_t       s1_item_r, s1_item_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  logic [BEAT_W-1:0] beat_r, beat_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [PIX_W-1:0]  out_value_r, out_value_nxt;
  logic              out_last_r, out_last_nxt;

  logic              last_beat, advance, s1_done;
  logic [SUM_W:0]    box_sum;

  assign last_beat = !s1_item_r.up || (beat_r == BEAT_LAST);
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign s1_done   = advance && last_beat;
  assign in_ready  = !s1_valid_r || s1_done;
  assign box_sum   = {1'b0, rd_data} + {1'b0, s1_item_r.pair};

  always_comb begin
    s1_item_nxt  = s1_item_r;
    s1_valid_nxt = s1_valid_r;
    beat_nxt     = beat_r;
    if (item_load) begin
      s1_item_nxt  = item;
      s1_valid_nxt = 1'b1;
      beat_nxt     = '0;
    end else if (s1_done) begin
      s1_valid_nxt = 1'b0;
      beat_nxt     = '0;
    end else if (advance) begin
      beat_nxt = beat_r + BEAT_W'(1);
    end
  end

  // Output register: one beat per transfer
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = last_beat;
      if (s1_item_r.up) begin
        out_row_nxt   = s1_item_r.row | ROW_W'(beat_r[1]);
        out_col_nxt   = s1_item_r.col | COL_W'(beat_r[0]);
        out_value_nxt = s1_item_r.pair[PIX_W-1:0];
      end else begin
        out_row_nxt   = s1_item_r.row;
        out_col_nxt   = s1_item_r.col;
        out_value_nxt = box_sum[SUM_W:2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      beat_r      <= beat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r   <= s1_item_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_row          = out_row_r;
  assign out_col          = out_col_r;
  assign out_value        = out_value_r;
  assign out_last_of_item = out_last_r;

  `ISBT_ASSERT_SAME(a_down_single_beat, clk, rst_n, s1_valid_r && !s1_item_r.up, beat_r == '0)
  `ISBT_ASSERT_SAME(a_no_overwrite, clk, rst_n, item_load, !s1_valid_r || s1_done)
  `ISBT_ASSERT_NEXT(a_last_reaches_out, clk, rst_n, s1_done, out_valid_r && out_last_r)

endmodule

// ===== hw/rtl/image_scale_by_two.sv =====
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+----------------------------------------
// in_      | input     | in_valid / in_ready     | in_pixel[7:0]
// out_     | output    | out_valid / out_ready   | out_row[12:0] out_col[10:0]
//          |           |                         | out_value[7:0] out_last_of_item
// cfg_     | input     | cfg_valid / cfg_ready   | cfg_index[1:0] cfg_data[12:0]
//
// Upscale: four results per pixel, one per cycle from the beat counter while the output
// is not stalled; the next pixel enters with the last beat. Downscale: at most one
// result per pixel, 1 pixel/cycle while the output is not stalled. The first result
// of a pixel passes the beat stage register, then the output register. The line store
// is a one-port-write, one-port-read RAM, registered read, no reset, no clearing pass.
// rst_n is synchronous, active low; it restores registers and frame position.
// A stalled output holds its register; the next pixel is taken as soon as the
// beat stage drains, so one finished result may wait while a pixel enters.
module image_scale_by_two #(
  parameter int MAX_WIDTH  = isbt_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = isbt_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [isbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [isbt_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [isbt_pkg::PIX_W-1:0]      in_pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [isbt_pkg::ROW_W-1:0]      out_row,
  output logic [isbt_pkg::COL_W-1:0]      out_col,
  output logic [isbt_pkg::PIX_W-1:0]      out_value,
  output logic                            out_last_of_item
);
  import isbt_pkg::*;

  // Column counter width; the line store is addressed by column / 2.
  localparam int CW    = ($clog2(MAX_WIDTH) > 2) ? $clog2(MAX_WIDTH) : 2;
  localparam int LAW   = CW - 1;
  localparam int DEPTH = MAX_WIDTH / 2;

  logic             in_fire;
  logic             item_load;
  scale_item_t      item;
  logic             wr_en, rd_en;
  logic [LAW-1:0]   wr_addr, rd_addr;
  logic [SUM_W-1:0] wr_data, rd_data;

  // Register writes are always taken at once.
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  // Frame position, mode and geometry registers and the held even-column pixel.
  isbt_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .in_pixel  (in_pixel),
    .item_load (item_load),
    .item      (item),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  // Pair sums of the even row. An entry is written at least two pixels before
  // the odd row reads it back, so no forwarding path is needed.
  isbt_line_mem #(
    .DEPTH (DEPTH),
    .AW    (LAW)
  ) u_line (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Beat stage and output register: expand, add the stored pair, hold on stall.
  isbt_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_load        (item_load),
    .item             (item),
    .rd_data          (rd_data),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_value        (out_value),
    .out_last_of_item (out_last_of_item)
  );

endmodule
